// ===== rtl/priority_task_scheduler_top_defines.svh =====
// Assertion macros used by the task scheduler top level.
`ifndef PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define PTS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pts_pkg.sv =====
// Shared constants, codes and types of the task scheduler.
`default_nettype none
package pts_pkg;

    localparam int NUM_NAMES = 16;
    localparam int MAX_TASKS = 8;

    localparam int NAME_W   = 4;
    localparam int IDX_W    = $clog2(NUM_NAMES);
    localparam int NEXT_W   = 5;
    localparam int DELAY_W  = 31;
    localparam int PERIOD_W = 10;
    localparam int ACT_W    = 4;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 3;
    localparam int STAT_W   = 3;

    localparam logic [NEXT_W-1:0] IDLE_TASK = NEXT_W'(NUM_NAMES);

    // actions
    localparam logic [ACT_W-1:0] ACT_TICK     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_ADD      = 4'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_DELAY    = 4'd3;
    localparam logic [ACT_W-1:0] ACT_RESUME   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_FREEZE   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_STATUS   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_SCHEDULE = 4'd7;
    localparam logic [ACT_W-1:0] ACT_ALL_DONE = 4'd8;

    // wait kinds
    localparam logic [KIND_W-1:0] WK_READY  = 2'd0;
    localparam logic [KIND_W-1:0] WK_NAP    = 2'd1;
    localparam logic [KIND_W-1:0] WK_FROZEN = 2'd2;
    localparam logic [KIND_W-1:0] WK_TIMED  = 2'd3;

    // task status
    localparam logic [STAT_W-1:0] ST_DELETED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_FROZEN    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NAPPING   = 3'd2;
    localparam logic [STAT_W-1:0] ST_READY     = 3'd3;
    localparam logic [STAT_W-1:0] ST_SUSPENDED = 3'd4;
    localparam logic [STAT_W-1:0] ST_RUNNING   = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_EXISTS    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_ILLEGAL   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_FULL      = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic              present;
        logic [STAT_W-1:0] status;
        logic [DELAY_W-1:0] delay;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_tbl_wr;

endpackage
`default_nettype wire

// ===== rtl/priority_task_scheduler_top.sv =====
// Top level of the task scheduler: command sequencer, table and divider.
//
// Hardware task manager for a cooperative kernel. Each command word carries
// an action, a task name (also its priority, lower is more urgent), a wait
// kind and a wait length in ms; every command returns exactly one response
// word with an error code, the task status (status command only), the running
// task (or the chosen task after schedule; 16 is the idle task) and the
// all-done flag. One command is worked on at a time and the input is not
// ready meanwhile. The task table is read and written at one shared address,
// so every sweep over it visits one entry at a time: tick and all done sweep
// every name, schedule stops at the first ready task (lowest name first) and,
// when none is ready, falls back to the idle task and sweeps again to wake
// the nappers. Add and delay with a timed wait run the ms-to-tick ceiling
// divide through a bit-serial divider, 31 quotient bits at one a cycle. A
// response waits in an output register, so the next command may be taken
// while the previous response is still held. The user must write the tick
// period register only while no command is in flight; the block itself does
// not enforce this. A period of zero counts as 1 ms.
`default_nettype none
`include "priority_task_scheduler_top_defines.svh"
module priority_task_scheduler_top #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick period register
    input  wire logic        i_cfg_wr_en,
    input  wire logic [9:0]  i_cfg_wr_data,   // tick_period_ms
    // command words
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,       // [3:0] task_name, [34:4] wait_ms
    input  wire logic [5:0]  i_s_tuser,       // [3:0] action, [5:4] wait_kind
    // response words
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata        // [2:0] error_code, [5:3] task_status,
                                              // [10:6] next_task, [11] all_done
);

    localparam int FREE_W  = $clog2(MAX_TASKS + 1);
    localparam int STATE_W = 4;
    localparam int IDX_W   = pts_pkg::IDX_W;
    localparam int NEXT_W  = pts_pkg::NEXT_W;

    localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STATE_W-1:0] S_LOOKUP = 4'd1;
    localparam logic [STATE_W-1:0] S_DIV    = 4'd2;
    localparam logic [STATE_W-1:0] S_TICK   = 4'd3;
    localparam logic [STATE_W-1:0] S_FIND   = 4'd4;
    localparam logic [STATE_W-1:0] S_WAKE   = 4'd5;
    localparam logic [STATE_W-1:0] S_SCAN   = 4'd6;
    localparam logic [STATE_W-1:0] S_RESP   = 4'd7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(pts_pkg::NUM_NAMES - 1);

    // control registers
    logic [STATE_W-1:0]             r_state,   n_state;
    logic [IDX_W-1:0]               r_idx,     n_idx;
    logic [NEXT_W-1:0]              r_running, n_running;
    logic [FREE_W-1:0]              r_free,    n_free;
    logic [pts_pkg::ERR_W-1:0]      r_err,     n_err;
    logic [pts_pkg::STAT_W-1:0]     r_status,  n_status;
    logic                           r_done,    n_done;
    logic                           r_out_valid;
    logic [pts_pkg::PERIOD_W-1:0]   r_period;

    // command payload, held for the whole command
    logic [pts_pkg::ACT_W-1:0]      r_act;
    logic [pts_pkg::NAME_W-1:0]     r_name;
    logic [pts_pkg::KIND_W-1:0]     r_kind;
    logic [pts_pkg::DELAY_W-1:0]    r_ms;
    logic [15:0]                    r_out_data;

    logic                           w_in_acc;
    logic                           w_out_load;
    logic [IDX_W-1:0]               w_addr;
    pts_pkg::t_entry                w_rd;
    pts_pkg::t_tbl_wr               w_wr;
    logic [pts_pkg::NUM_NAMES-1:0]  w_present;
    logic                           w_name_ok;
    logic                           w_run_ok;
    logic                           w_need_div;
    logic [pts_pkg::STAT_W-1:0]     w_wait_status;
    logic [pts_pkg::PERIOD_W-1:0]   w_per;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [pts_pkg::DELAY_W-1:0]    w_div_quot;
    logic [pts_pkg::DELAY_W-1:0]    w_dec;
    logic                           w_slots_ok;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    // table address: sweep index while scanning, else the running task for
    // delay and schedule, else the named task
    always_comb begin
        if (r_state == S_TICK || r_state == S_FIND || r_state == S_WAKE ||
            r_state == S_SCAN) begin
            w_addr = r_idx;
        end else if (r_act == pts_pkg::ACT_DELAY || r_act == pts_pkg::ACT_SCHEDULE) begin
            w_addr = r_running[IDX_W-1:0];
        end else begin
            w_addr = IDX_W'(r_name);
        end
    end

    assign w_name_ok = {1'b0, r_name} < NEXT_W'(pts_pkg::NUM_NAMES);
    assign w_run_ok  = r_running < NEXT_W'(pts_pkg::NUM_NAMES);
    assign w_per     = (r_period == '0) ? pts_pkg::PERIOD_W'(1) : r_period;
    assign w_dec     = w_rd.delay - pts_pkg::DELAY_W'(1);

    // wait request decode; a timed wait of zero ms means ready now
    assign w_need_div = (r_kind == pts_pkg::WK_TIMED) && (r_ms != '0);
    always_comb begin
        case (r_kind)
            pts_pkg::WK_READY:  w_wait_status = pts_pkg::ST_READY;
            pts_pkg::WK_NAP:    w_wait_status = pts_pkg::ST_NAPPING;
            pts_pkg::WK_FROZEN: w_wait_status = pts_pkg::ST_FROZEN;
            default:            w_wait_status = pts_pkg::ST_READY;
        endcase
    end

    assign w_out_load = (r_state == S_RESP) && (!r_out_valid || i_m_tready);

    // command sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_running   = r_running;
        n_free      = r_free;
        n_err       = r_err;
        n_status    = r_status;
        n_done      = r_done;
        w_div_start = 1'b0;
        w_wr.en     = 1'b0;
        w_wr.addr   = w_addr;
        w_wr.data   = '{present: 1'b1, status: w_wait_status, delay: '0};

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_err    = pts_pkg::ERR_OK;
                    n_status = pts_pkg::ST_DELETED;
                    n_done   = 1'b0;
                    n_idx    = '0;
                    case (i_s_tuser[3:0])
                        pts_pkg::ACT_TICK: n_state = S_TICK;
                        pts_pkg::ACT_ALL_DONE: begin
                            n_done  = 1'b1;
                            n_state = S_SCAN;
                        end
                        pts_pkg::ACT_ADD, pts_pkg::ACT_DELETE, pts_pkg::ACT_DELAY,
                        pts_pkg::ACT_RESUME, pts_pkg::ACT_FREEZE, pts_pkg::ACT_STATUS,
                        pts_pkg::ACT_SCHEDULE: n_state = S_LOOKUP;
                        default: begin
                            n_err   = pts_pkg::ERR_ILLEGAL;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_LOOKUP: begin
                n_state = S_RESP;
                case (r_act)
                    pts_pkg::ACT_ADD: begin
                        if (!w_name_ok) begin
                            n_err = pts_pkg::ERR_ILLEGAL;
                        end else if (w_rd.present) begin
                            n_err = pts_pkg::ERR_EXISTS;
                        end else if (r_free == '0) begin
                            n_err = pts_pkg::ERR_FULL;
                        end else if (w_need_div) begin
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end else begin
                            w_wr.en = 1'b1;
                            n_free  = r_free - FREE_W'(1);
                        end
                    end
                    pts_pkg::ACT_DELETE: begin
                        if (!w_name_ok || !w_rd.present) begin
                            n_err = pts_pkg::ERR_NOT_FOUND;
                        end else begin
                            w_wr.en   = 1'b1;
                            w_wr.data = '{present: 1'b0, status: pts_pkg::ST_DELETED,
                                          delay: '0};
                            if (r_free < FREE_W'(MAX_TASKS)) begin
                                n_free = r_free + FREE_W'(1);
                            end
                        end
                    end
                    pts_pkg::ACT_DELAY: begin
                        if (!w_run_ok || !w_rd.present) begin
                            n_err = pts_pkg::ERR_ILLEGAL;
                        end else if (w_need_div) begin
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end else begin
                            w_wr.en = 1'b1;
                        end
                    end
                    pts_pkg::ACT_RESUME, pts_pkg::ACT_FREEZE: begin
                        if (!w_name_ok) begin
                            n_err = pts_pkg::ERR_ILLEGAL;
                        end else if (!w_rd.present) begin
                            n_err = pts_pkg::ERR_NOT_FOUND;
                        end else begin
                            w_wr.en          = 1'b1;
                            w_wr.data.status = (r_act == pts_pkg::ACT_RESUME) ?
                                               pts_pkg::ST_READY : pts_pkg::ST_FROZEN;
                        end
                    end
                    pts_pkg::ACT_STATUS: begin
                        if (!w_name_ok) begin
                            n_err = pts_pkg::ERR_ILLEGAL;
                        end else if (!w_rd.present) begin
                            n_err = pts_pkg::ERR_NOT_FOUND;
                        end else begin
                            n_status = w_rd.status;
                        end
                    end
                    pts_pkg::ACT_SCHEDULE: begin
                        // nap the running task before the search
                        if (w_run_ok && w_rd.present &&
                            w_rd.status == pts_pkg::ST_RUNNING) begin
                            w_wr.en          = 1'b1;
                            w_wr.data.status = pts_pkg::ST_NAPPING;
                        end
                        n_idx   = '0;
                        n_state = S_FIND;
                    end
                    default: n_err = pts_pkg::ERR_ILLEGAL;
                endcase
            end

            S_DIV: begin
                if (w_div_done) begin
                    w_wr.en   = 1'b1;
                    w_wr.data = '{present: 1'b1, status: pts_pkg::ST_SUSPENDED,
                                  delay: w_div_quot};
                    if (r_act == pts_pkg::ACT_ADD) begin
                        n_free = r_free - FREE_W'(1);
                    end
                    n_state = S_RESP;
                end
            end

            S_TICK: begin
                if (w_rd.present && w_rd.delay != '0) begin
                    w_wr.en   = 1'b1;
                    w_wr.data = '{present: 1'b1,
                                  status: (w_dec == '0) ? pts_pkg::ST_READY : w_rd.status,
                                  delay: w_dec};
                end
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = S_RESP;
                end
            end

            S_FIND: begin
                n_idx = r_idx + IDX_W'(1);
                if (w_rd.present && w_rd.status == pts_pkg::ST_READY) begin
                    w_wr.en   = 1'b1;
                    w_wr.data = '{present: 1'b1, status: pts_pkg::ST_RUNNING,
                                  delay: w_rd.delay};
                    n_running = NEXT_W'(r_idx);
                    n_state   = S_RESP;
                end else if (r_idx == LAST_IDX) begin
                    // nothing ready: fall back to idle and wake the nappers
                    n_running = pts_pkg::IDLE_TASK;
                    n_idx     = '0;
                    n_state   = S_WAKE;
                end
            end

            S_WAKE: begin
                if (w_rd.present && w_rd.status == pts_pkg::ST_NAPPING) begin
                    w_wr.en   = 1'b1;
                    w_wr.data = '{present: 1'b1, status: pts_pkg::ST_READY,
                                  delay: w_rd.delay};
                end
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = S_RESP;
                end
            end

            S_SCAN: begin
                if (w_rd.present && w_rd.status > pts_pkg::ST_FROZEN) begin
                    n_done = 1'b0;
                end
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                // hold until the output register is free
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_running   <= pts_pkg::IDLE_TASK;
            r_free      <= FREE_W'(MAX_TASKS);
            r_err       <= pts_pkg::ERR_OK;
            r_status    <= pts_pkg::ST_DELETED;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= pts_pkg::PERIOD_W'(1);
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_running <= n_running;
            r_free    <= n_free;
            r_err     <= n_err;
            r_status  <= n_status;
            r_done    <= n_done;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act  <= i_s_tuser[3:0];
            r_kind <= i_s_tuser[5:4];
            r_name <= i_s_tdata[3:0];
            r_ms   <= i_s_tdata[34:4];
        end
        if (w_out_load) begin
            r_out_data <= {4'b0000, r_done, r_running, r_status, r_err};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    pts_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_addr),
        .i_wr      (w_wr),
        .o_rd      (w_rd),
        .o_present (w_present)
    );

    pts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_ms),
        .i_divisor  (w_per),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign w_slots_ok = ($countones(w_present) + 32'(r_free)) == MAX_TASKS;

    // every slot is either held by a present task or free
    `PTS_ASSERT_ALWAYS(a_slot_count, i_clk, i_rst_n, w_slots_ok, "tasks and free slots disagree")
    // a word taken closes the input until its response is queued
    `PTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !o_s_tready, "ready too soon")
    // the divider only finishes while the sequencer waits for it
    `PTS_ASSERT_IMPL(a_div_owner, i_clk, i_rst_n, w_div_done, r_state == S_DIV, "stray divide")
    // the running task is a real name or the idle task
    `PTS_ASSERT_ALWAYS(a_running_range, i_clk, i_rst_n, r_running <= pts_pkg::IDLE_TASK, "bad running task")

endmodule
`default_nettype wire

// ===== rtl/pts_div.sv =====
// Bit-serial ceiling divider: one quotient bit per cycle.
`default_nettype none
module pts_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [pts_pkg::DELAY_W-1:0]  i_dividend,
    input  wire logic [pts_pkg::PERIOD_W-1:0] i_divisor,
    output logic                              o_done,
    output logic [pts_pkg::DELAY_W-1:0]       o_quot
);

    localparam int CNT_W = $clog2(pts_pkg::DELAY_W);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [pts_pkg::PERIOD_W-1:0] r_rem;
    logic [pts_pkg::PERIOD_W-1:0] r_div;
    logic [pts_pkg::DELAY_W-1:0]  r_quo;

    logic [pts_pkg::PERIOD_W:0]   w_trial;
    logic [pts_pkg::PERIOD_W:0]   w_diff;
    logic                         w_ge;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_quo[pts_pkg::DELAY_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(pts_pkg::DELAY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[pts_pkg::PERIOD_W-1:0] : w_trial[pts_pkg::PERIOD_W-1:0];
            r_quo <= {r_quo[pts_pkg::DELAY_W-2:0], w_ge};
        end
    end

    // round up when anything is left over
    assign o_done = r_done;
    assign o_quot = r_quo + pts_pkg::DELAY_W'(r_rem != '0);

endmodule
`default_nettype wire

// ===== rtl/pts_table.sv =====
// Task table: one entry per name, one read and one write address a cycle.
`default_nettype none
module pts_table (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [pts_pkg::IDX_W-1:0]  i_rd_addr,
    input  wire pts_pkg::t_tbl_wr           i_wr,
    output pts_pkg::t_entry                 o_rd,
    output logic [pts_pkg::NUM_NAMES-1:0]   o_present
);

    pts_pkg::t_entry r_entry [pts_pkg::NUM_NAMES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pts_pkg::NUM_NAMES; i++) begin
                r_entry[i] <= '{present: 1'b0, status: pts_pkg::ST_DELETED, delay: '0};
            end
        end else if (i_wr.en) begin
            r_entry[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd = r_entry[i_rd_addr];

    always_comb begin
        for (int i = 0; i < pts_pkg::NUM_NAMES; i++) begin
            o_present[i] = r_entry[i].present;
        end
    end

endmodule
`default_nettype wire
